@@ hdl/fesf_pkg.sv @@
// ----------------------------------------------------------------------------
// fesf_pkg
// Shared constants and types for the fire effect seven-tap averaging filter.
// ----------------------------------------------------------------------------
package fesf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int FIELD_W = 10;   // width of the out_row and out_col fields
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);

    // clamped width is held as width-1, always in [2, MAX_WIDTH-1]
    localparam int LAST_MAX   = MAX_WIDTH - 1;
    localparam int LAST_MIN   = 2;
    localparam int LAST_RESET = ((1024 < MAX_WIDTH) ? 1024 : MAX_WIDTH) - 1;

    // seven-tap sum and divide by seven through a reciprocal
    localparam int TAPS        = 7;
    localparam int SUM_W       = 11;
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP7      = ((1 << RECIP_SHIFT) + TAPS - 1) / TAPS;
    localparam int RECIP_W     = 12;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // one row store entry: old value of row i-2 over old value of row i-1
    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] middle;
    } row_entry_t;

    localparam int ENTRY_W = $bits(row_entry_t);

    typedef logic [TAPS-1:0][PIX_W-1:0] taps_t;

endpackage

@@ hdl/fesf_ram.sv @@
// ----------------------------------------------------------------------------
// fesf_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fesf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the contents before a write at the same edge
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/fesf_average.sv @@
// ----------------------------------------------------------------------------
// fesf_average
// Sum of seven 8-bit taps divided by seven, truncated.
// ----------------------------------------------------------------------------
module fesf_average (
    input  fesf_pkg::taps_t                taps,
    output logic [fesf_pkg::PIX_W-1:0]     avg
);

    logic [fesf_pkg::SUM_W-1:0]  sum;
    logic [fesf_pkg::PROD_W-1:0] prod;

    always_comb begin
        sum = '0;
        for (int k = 0; k < fesf_pkg::TAPS; k++) begin
            sum = sum + fesf_pkg::SUM_W'(taps[k]);
        end
    end

    // reciprocal error stays below 1/7 of the sum range, so floor is exact
    assign prod = fesf_pkg::PROD_W'(sum)
                * fesf_pkg::PROD_W'(fesf_pkg::RECIP7);
    assign avg  = prod[fesf_pkg::RECIP_SHIFT +: fesf_pkg::PIX_W];

endmodule

@@ hdl/fire_effect_stencil_filter.sv @@
// ----------------------------------------------------------------------------
// fire_effect_stencil_filter
// Streaming seven-tap averaging filter for a fire effect on 8-bit pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock while s_ready is high, with
// s_frame_start on the first pixel of a frame. The old values of the two
// previous rows live in one RAM of MAX_WIDTH entries, read at the column of
// the incoming pixel and written back as it leaves stage 1, with a bypass
// when the next pixel hits the same column. Once a pixel at row 2 or below
// and column 2 up to width-1 arrives, the block returns the new value of the
// pixel two rows up and one column left; other pixels produce no item. The
// sustained rate is one pixel per clock unless the output stalls, set by the
// recursive left tap, which closes through the adder tree and reciprocal
// multiplier. The row RAM is not cleared: its contents are meaningful once
// two rows of the current width have gone through. frame_width may be
// written only while the block is idle and is clamped to [3, MAX_WIDTH].
// ----------------------------------------------------------------------------
module fire_effect_stencil_filter (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fesf_pkg::CFG_W-1:0]          cfg_frame_width,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fesf_pkg::PIX_W-1:0]          s_pixel_value,
    input  logic                                s_frame_start,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fesf_pkg::FIELD_W-1:0]        m_out_row,
    output logic [fesf_pkg::FIELD_W-1:0]        m_out_col,
    output logic [fesf_pkg::PIX_W-1:0]          m_out_value
);

    localparam int CW = fesf_pkg::COL_W;
    localparam int RW = fesf_pkg::ROW_W;
    localparam int PW = fesf_pkg::PIX_W;

    // configuration
    logic [CW-1:0] last_col_reg, last_col_next;

    // position counters
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;

    // stage 1: row RAM read in flight
    logic          s1_valid_reg, s1_valid_next;
    logic [CW-1:0] s1_col_reg, s1_col_next;
    logic [RW-1:0] s1_row_reg, s1_row_next;
    logic [PW-1:0] s1_pix_reg, s1_pix_next;
    logic          s1_emit_reg, s1_emit_next;
    logic          fwd_hit_reg, fwd_hit_next;
    fesf_pkg::row_entry_t fwd_data_reg, fwd_data_next;

    // window: [0],[1] row i-2 at j-1, j-2; [2],[3] row i-1; [4],[5] row i
    logic [5:0][PW-1:0] win_reg, win_next;
    logic [PW-1:0]      prev_reg, prev_next;

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic [fesf_pkg::FIELD_W-1:0] m_row_reg, m_row_next;
    logic [fesf_pkg::FIELD_W-1:0] m_col_reg, m_col_next;
    logic [PW-1:0]                m_value_reg, m_value_next;

    logic                 s_accept;
    logic                 s1_adv;
    logic [CW-1:0]        cur_col;
    logic [RW-1:0]        cur_row;
    fesf_pkg::row_entry_t rd_entry;
    fesf_pkg::row_entry_t up_entry;
    fesf_pkg::row_entry_t wr_entry;
    fesf_pkg::taps_t      taps;
    logic [PW-1:0]        avg;
    logic [fesf_pkg::CFG_W:0] cfg_ext;

    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || s1_adv;
    assign s_accept  = s_valid && s_ready;

    assign cur_col = s_frame_start ? '0 : col_count_reg;
    assign cur_row = s_frame_start ? '0 : row_count_reg;

    fesf_ram #(
        .WIDTH (fesf_pkg::ENTRY_W),
        .DEPTH (fesf_pkg::MAX_WIDTH)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (wr_entry),
        .rd_en   (s_accept),
        .rd_addr (cur_col),
        .rd_data (rd_entry)
    );

    assign up_entry        = fwd_hit_reg ? fwd_data_reg : rd_entry;
    assign wr_entry.older  = up_entry.middle;
    assign wr_entry.middle = s1_pix_reg;

    // left tap: column 0 is never recomputed, so column 1 takes its old value
    assign taps[0] = (s1_col_reg == CW'(2)) ? win_reg[1] : prev_reg;
    assign taps[1] = up_entry.older;
    assign taps[2] = win_reg[3];
    assign taps[3] = up_entry.middle;
    assign taps[4] = win_reg[5];
    assign taps[5] = win_reg[4];
    assign taps[6] = s1_pix_reg;

    fesf_average u_average (
        .taps (taps),
        .avg  (avg)
    );

    assign cfg_ext = {1'b0, cfg_frame_width};

    always_comb begin
        last_col_next  = last_col_reg;
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        s1_valid_next  = s1_valid_reg;
        s1_col_next    = s1_col_reg;
        s1_row_next    = s1_row_reg;
        s1_pix_next    = s1_pix_reg;
        s1_emit_next   = s1_emit_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_data_next  = fwd_data_reg;
        win_next       = win_reg;
        prev_next      = prev_reg;
        m_valid_next   = m_valid_reg;
        m_row_next     = m_row_reg;
        m_col_next     = m_col_reg;
        m_value_next   = m_value_reg;

        if (cfg_valid) begin
            if (int'(cfg_ext) - 1 > fesf_pkg::LAST_MAX) begin
                last_col_next = CW'(fesf_pkg::LAST_MAX);
            end else if (int'(cfg_ext) - 1 < fesf_pkg::LAST_MIN) begin
                last_col_next = CW'(fesf_pkg::LAST_MIN);
            end else begin
                last_col_next = CW'(cfg_ext - 1'b1);
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s1_adv) begin
            s1_valid_next = 1'b0;
            win_next[1]   = win_reg[0];
            win_next[0]   = up_entry.older;
            win_next[3]   = win_reg[2];
            win_next[2]   = up_entry.middle;
            win_next[5]   = win_reg[4];
            win_next[4]   = s1_pix_reg;
            if (s1_emit_reg) begin
                prev_next    = avg;
                m_valid_next = 1'b1;
                m_row_next   = fesf_pkg::FIELD_W'(s1_row_reg - RW'(2));
                m_col_next   = fesf_pkg::FIELD_W'(s1_col_reg - CW'(1));
                m_value_next = avg;
            end
        end

        if (s_accept) begin
            s1_valid_next = 1'b1;
            s1_col_next   = cur_col;
            s1_row_next   = cur_row;
            s1_pix_next   = s_pixel_value;
            s1_emit_next  = (cur_row >= RW'(2)) && (cur_col >= CW'(2))
                         && (cur_col <= last_col_reg);
            // same column written back at this edge: take the new entry
            fwd_hit_next  = s1_adv && (s1_col_reg == cur_col);
            fwd_data_next = wr_entry;
            if (cur_col >= last_col_reg) begin
                col_count_next = '0;
                row_count_next = (cur_row == RW'(fesf_pkg::MAX_HEIGHT - 1))
                               ? '0 : cur_row + 1'b1;
            end else begin
                col_count_next = cur_col + 1'b1;
                row_count_next = cur_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg  <= CW'(fesf_pkg::LAST_RESET);
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            prev_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            last_col_reg  <= last_col_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            prev_reg      <= prev_next;
            m_valid_reg   <= m_valid_next;
        end
        s1_col_reg   <= s1_col_next;
        s1_row_reg   <= s1_row_next;
        s1_pix_reg   <= s1_pix_next;
        s1_emit_reg  <= s1_emit_next;
        fwd_data_reg <= fwd_data_next;
        win_reg      <= win_next;
        m_row_reg    <= m_row_next;
        m_col_reg    <= m_col_next;
        m_value_reg  <= m_value_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_row   = m_row_reg;
    assign m_out_col   = m_col_reg;
    assign m_out_value = m_value_reg;

endmodule
